FILE: hdl/assert_macros.svh
// Assertion helpers for the colour map checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ecm_pkg.sv
package ecm_pkg;

    localparam int unsigned FULL_SCALE = 65536;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] STAT_ANSWER  = 2'd0;
    localparam logic [1:0] STAT_BUILT   = 2'd1;
    localparam logic [1:0] STAT_DROPPED = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] stress_sample;
        logic        last_sample;
        logic [16:0] query_value;
    } t_in_word;

    typedef struct packed {
        logic [16:0] color_value;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_WAIT,
        S_SORT_CMP,
        S_SORT_WR,
        S_SORT_NEXT,
        S_MINMAX_RD,
        S_MINMAX_WAIT,
        S_MINMAX_CAP,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_DIV,
        S_WALK_DECIDE,
        S_WALK_MAP,
        S_WALK_STEP,
        S_BUILD_DONE,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_CHECK,
        S_Q_DIV,
        S_Q_DONE
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/ecm_ram.sv
module ecm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/ecm_div.sv
// Restoring divider, one quotient bit per cycle.
module ecm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecm_pkg::t_div_req i_req,
    output ecm_pkg::t_div_rsp o_rsp
);

    logic [47:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[47]} - {1'b0, r_den};
        if (!w_trial[33]) begin
            n_rem = w_trial[32:0];
            n_quo = {r_quo[46:0], 1'b1};
        end else begin
            n_rem = {r_rem[31:0], r_quo[47]};
            n_quo = {r_quo[46:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = {r_done, r_quo};

endmodule

FILE: hdl/equalized_color_map.sv
// Histogram-equalising colour map. Send a word with start while busy is low.
// A load stores one sample (dropped once the store is full) and, unless it
// is the last sample, gives no result. The last sample starts a build: an
// insertion sort of the sample store through one RAM port, then, unless the
// set has under two samples or is constant, a walk over the sorted store
// with one divide per sample and per breakpoint map value. A query scans
// the breakpoint table (up to BIN_COUNT+1 entries) and then divides once if
// the query falls between two breakpoints. Each result is shown for one
// cycle with o_valid; the receiver cannot stall, so the word must be taken
// when the strobe is high.
module equalized_color_map #(
    parameter int MAX_SAMPLES = 1024,
    parameter int BIN_COUNT   = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ecm_pkg::t_in_word i_word,
    output logic              o_valid,
    output ecm_pkg::t_out_word o_word
);

    localparam int SAW = $clog2(MAX_SAMPLES);
    localparam int SCW = $clog2(MAX_SAMPLES + 1);
    localparam int TD  = BIN_COUNT + 1;
    localparam int TAW = $clog2(TD);
    localparam int TCW = $clog2(TD + 1);
    // Grid step 65536/BIN_COUNT split into quotient and remainder.
    localparam int GQ  = ecm_pkg::FULL_SCALE / BIN_COUNT;
    localparam int GR  = ecm_pkg::FULL_SCALE % BIN_COUNT;
    localparam int RW  = $clog2(BIN_COUNT);
    localparam int RSW = RW + 1;

    ecm_pkg::t_state r_state, n_state;

    logic [SCW-1:0] r_count;
    logic           r_ovf;
    logic [TCW-1:0] r_bp_count;

    // Sort indices: outer i, inner j, held value v.
    logic [SCW-1:0] r_i, r_j;
    logic [31:0]    r_v, r_lo, r_span;
    logic [SCW-1:0] r_cum, r_run;
    logic [TCW-1:0] r_cnt;
    logic [16:0]    r_norm;
    logic [16:0]    r_q, r_a, r_ma;
    logic [16:0]    r_result;
    logic [1:0]     r_status;

    // Grid point k held as quotient and remainder of k*65536/BIN_COUNT.
    logic [16:0]    r_gq;
    logic [RW-1:0]  r_gr, n_gr;
    logic [RSW-1:0] w_rsum;
    logic           w_wrap;

    // Sample RAM.
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [31:0]    s_wdata, s_rdata;

    // Table RAM: breakpoint and map value side by side.
    logic           t_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [33:0]    t_wdata, t_rdata;

    ecm_pkg::t_div_req div_req;
    ecm_pkg::t_div_rsp div_rsp;

    ecm_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_samples (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    ecm_ram #(.WIDTH(34), .DEPTH(TD)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    ecm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic        accept;
    logic        sorted_gt;
    logic [31:0] diff;
    logic [16:0] g_k, g_k1;

    assign accept    = start && !busy;
    assign sorted_gt = $signed(s_rdata) > $signed(r_v);
    assign diff      = s_rdata - r_lo;

    // Advance k by adding the step and carrying the remainder.
    assign w_rsum = {1'b0, r_gr} + RSW'(GR);
    assign w_wrap = (w_rsum >= RSW'(BIN_COUNT));
    assign n_gr   = w_wrap ? RW'(w_rsum - RSW'(BIN_COUNT)) : RW'(w_rsum);
    assign g_k    = r_gq;
    assign g_k1   = r_gq + 17'(GQ) + 17'(w_wrap);

    always_comb begin
        n_state = r_state;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        div_req = '0;
        busy = (r_state != ecm_pkg::S_IDLE);
        unique case (r_state)
            ecm_pkg::S_IDLE: begin
                s_waddr = r_count[SAW-1:0];
                s_wdata = i_word.stress_sample;
                if (accept) begin
                    if (i_word.req_type == ecm_pkg::REQ_QUERY) begin
                        n_state = ecm_pkg::S_Q_RD;
                    end else begin
                        s_we = (r_count < SCW'(MAX_SAMPLES));
                        if (i_word.last_sample) n_state = ecm_pkg::S_SORT_NEXT;
                    end
                end
            end
            // Insertion sort: load v = store[i], shift larger entries up.
            ecm_pkg::S_SORT_NEXT: begin
                s_raddr = r_i[SAW-1:0];
                n_state = (r_i < r_count) ? ecm_pkg::S_SORT_RD : ecm_pkg::S_MINMAX_RD;
            end
            ecm_pkg::S_SORT_RD: begin
                s_raddr = SAW'(r_j - SCW'(1));
                n_state = (r_j == '0) ? ecm_pkg::S_SORT_WR : ecm_pkg::S_SORT_WAIT;
            end
            ecm_pkg::S_SORT_WAIT: begin
                // Hold the address so store[j-1] is still on the port.
                s_raddr = SAW'(r_j - SCW'(1));
                n_state = ecm_pkg::S_SORT_CMP;
            end
            ecm_pkg::S_SORT_CMP: begin
                s_waddr = r_j[SAW-1:0];
                s_wdata = s_rdata;
                if (sorted_gt) begin
                    s_we = 1'b1;
                    n_state = ecm_pkg::S_SORT_RD;
                end else begin
                    n_state = ecm_pkg::S_SORT_WR;
                end
            end
            ecm_pkg::S_SORT_WR: begin
                s_we = 1'b1; s_waddr = r_j[SAW-1:0]; s_wdata = r_v;
                n_state = ecm_pkg::S_SORT_NEXT;
            end
            ecm_pkg::S_MINMAX_RD: begin
                s_raddr = SAW'(r_count - SCW'(1));
                n_state = (r_count < SCW'(2)) ? ecm_pkg::S_BUILD_DONE
                                              : ecm_pkg::S_MINMAX_WAIT;
            end
            ecm_pkg::S_MINMAX_WAIT: begin
                s_raddr = SAW'(r_count - SCW'(1));
                n_state = ecm_pkg::S_MINMAX_CAP;
            end
            ecm_pkg::S_MINMAX_CAP: begin
                t_we = (s_rdata != r_lo); t_waddr = '0; t_wdata = '0;
                n_state = (s_rdata == r_lo) ? ecm_pkg::S_BUILD_DONE
                                            : ecm_pkg::S_WALK_RD;
            end
            ecm_pkg::S_WALK_RD: begin
                s_raddr = r_i[SAW-1:0];
                n_state = (r_i < r_count && r_cnt < TCW'(TD)) ? ecm_pkg::S_WALK_WAIT
                                                              : ecm_pkg::S_BUILD_DONE;
            end
            ecm_pkg::S_WALK_WAIT: begin
                div_req.start = 1'b1;
                div_req.dividend = {diff, 16'd0};
                div_req.divisor = {1'b0, r_span};
                n_state = ecm_pkg::S_WALK_DIV;
            end
            ecm_pkg::S_WALK_DIV: begin
                if (div_rsp.done) n_state = ecm_pkg::S_WALK_DECIDE;
            end
            ecm_pkg::S_WALK_DECIDE: begin
                t_waddr = r_cnt[TAW-1:0];
                t_wdata = {17'(ecm_pkg::FULL_SCALE), 17'(ecm_pkg::FULL_SCALE)};
                if (r_norm < g_k) begin
                    n_state = ecm_pkg::S_WALK_STEP;
                end else if (r_norm == 17'(ecm_pkg::FULL_SCALE)) begin
                    t_we = 1'b1;
                    n_state = ecm_pkg::S_BUILD_DONE;
                end else if (r_norm >= g_k1) begin
                    n_state = ecm_pkg::S_WALK_DECIDE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = 48'({r_cum + r_run, 16'd0});
                    div_req.divisor = 33'(r_count);
                    n_state = ecm_pkg::S_WALK_MAP;
                end
            end
            ecm_pkg::S_WALK_MAP: begin
                t_waddr = r_cnt[TAW-1:0];
                t_wdata = {g_k, div_rsp.quotient[16:0]};
                if (div_rsp.done) begin
                    t_we = 1'b1;
                    n_state = ecm_pkg::S_WALK_STEP;
                end
            end
            ecm_pkg::S_WALK_STEP: n_state = ecm_pkg::S_WALK_RD;
            ecm_pkg::S_BUILD_DONE: n_state = ecm_pkg::S_IDLE;
            // Query scan: entry i and i+1 read on successive cycles.
            ecm_pkg::S_Q_RD: begin
                t_raddr = r_cnt[TAW-1:0];
                n_state = (r_q == 17'(ecm_pkg::FULL_SCALE) || r_cnt + TCW'(1) >= r_bp_count)
                          ? ecm_pkg::S_Q_DONE : ecm_pkg::S_Q_WAIT;
            end
            ecm_pkg::S_Q_WAIT: begin
                t_raddr = TAW'(r_cnt + TCW'(1));
                n_state = ecm_pkg::S_Q_CHECK;
            end
            ecm_pkg::S_Q_CHECK: begin
                // t_rdata now holds entry i+1, r_a/r_ma entry i.
                if (r_q >= r_a && r_q < t_rdata[33:17]) begin
                    div_req.start = 1'b1;
                    div_req.dividend = 48'(34'(r_q - r_a) *
                        34'((t_rdata[16:0] >= r_ma) ? (t_rdata[16:0] - r_ma) : 17'd0));
                    div_req.divisor = 33'(t_rdata[33:17] - r_a);
                    n_state = ecm_pkg::S_Q_DIV;
                end else begin
                    n_state = ecm_pkg::S_Q_RD;
                end
            end
            ecm_pkg::S_Q_DIV: if (div_rsp.done) n_state = ecm_pkg::S_Q_DONE;
            ecm_pkg::S_Q_DONE: n_state = ecm_pkg::S_IDLE;
            default: n_state = ecm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ecm_pkg::S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_bp_count <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                ecm_pkg::S_IDLE: begin
                    r_i <= SCW'(1); r_cnt <= '0;
                    r_q <= i_word.query_value;
                    r_result <= 17'(ecm_pkg::FULL_SCALE);
                    if (accept && i_word.req_type == ecm_pkg::REQ_LOAD) begin
                        // The first sample of a set seeds the minimum.
                        if (r_count == '0) r_lo <= i_word.stress_sample;
                        if (r_count < SCW'(MAX_SAMPLES)) r_count <= r_count + SCW'(1);
                        else r_ovf <= 1'b1;
                        if (i_word.last_sample) begin
                            r_status <= (r_count >= SCW'(MAX_SAMPLES) || r_ovf)
                                        ? ecm_pkg::STAT_DROPPED : ecm_pkg::STAT_BUILT;
                        end
                    end else begin
                        r_status <= ecm_pkg::STAT_ANSWER;
                    end
                end
                ecm_pkg::S_SORT_NEXT: r_j <= r_i;
                ecm_pkg::S_SORT_RD: if (r_j == r_i) r_v <= s_rdata;
                ecm_pkg::S_SORT_CMP: if (sorted_gt) r_j <= r_j - SCW'(1);
                ecm_pkg::S_SORT_WR: begin
                    r_i <= r_i + SCW'(1);
                    r_lo <= (r_j == '0) ? r_v : r_lo;
                end
                ecm_pkg::S_MINMAX_RD: begin
                    r_bp_count <= '0;
                    r_i <= SCW'(1);
                    r_gq <= 17'(GQ); r_gr <= RW'(GR);
                    r_cum <= '0; r_run <= SCW'(1); r_cnt <= TCW'(1);
                end
                ecm_pkg::S_MINMAX_CAP: r_span <= s_rdata - r_lo;
                ecm_pkg::S_WALK_DIV: if (div_rsp.done) r_norm <= div_rsp.quotient[16:0];
                ecm_pkg::S_WALK_DECIDE: begin
                    if (r_norm < g_k) begin
                        r_run <= r_run + SCW'(1);
                    end else if (r_norm == 17'(ecm_pkg::FULL_SCALE)) begin
                        r_cnt <= r_cnt + TCW'(1);
                    end else if (r_norm >= g_k1) begin
                        r_gq <= g_k1; r_gr <= n_gr;
                    end
                end
                ecm_pkg::S_WALK_MAP: if (div_rsp.done) begin
                    r_cum <= r_cum + r_run;
                    r_run <= SCW'(1);
                    r_gq  <= g_k1; r_gr <= n_gr;
                    r_cnt <= r_cnt + TCW'(1);
                end
                ecm_pkg::S_WALK_STEP: r_i <= r_i + SCW'(1);
                ecm_pkg::S_BUILD_DONE: begin
                    r_bp_count <= (r_count >= SCW'(2) && r_cnt > TCW'(1)) ? r_cnt : '0;
                    r_count <= '0; r_ovf <= 1'b0;
                    o_valid <= 1'b1;
                end
                ecm_pkg::S_Q_WAIT: begin
                    r_a <= t_rdata[33:17]; r_ma <= t_rdata[16:0];
                end
                ecm_pkg::S_Q_CHECK: r_cnt <= r_cnt + TCW'(1);
                ecm_pkg::S_Q_DIV: if (div_rsp.done)
                    r_result <= 17'(r_ma + div_rsp.quotient[16:0]);
                ecm_pkg::S_Q_DONE: o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Sort leaves walk counters in place; table build count is only kept on
    // success, so a constant set reads as no table.
    always_comb begin
        o_word.color_value = (r_status == ecm_pkg::STAT_ANSWER) ? r_result : 17'd0;
        o_word.status      = r_status;
    end

endmodule

FILE: hdl/ecm_checker.sv
`include "assert_macros.svh"

module ecm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_valid,
    input ecm_pkg::t_out_word i_out_word
);

    logic w_code_ok;
    logic w_built;
    logic w_zero;
    logic w_in_range;

    assign w_code_ok  = (i_out_word.status == ecm_pkg::STAT_ANSWER) ||
                        (i_out_word.status == ecm_pkg::STAT_BUILT) ||
                        (i_out_word.status == ecm_pkg::STAT_DROPPED);
    assign w_built    = (i_out_word.status != ecm_pkg::STAT_ANSWER);
    assign w_zero     = (i_out_word.color_value == 17'd0);
    assign w_in_range = (i_out_word.color_value <= 17'(ecm_pkg::FULL_SCALE));

    `ASSERT_IMPL(a_status_range, i_clk, i_rst_n, i_valid, w_code_ok)
    `ASSERT_IMPL(a_build_zero, i_clk, i_rst_n, i_valid && w_built, w_zero)
    `ASSERT_IMPL(a_color_range, i_clk, i_rst_n, i_valid, w_in_range)
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, i_valid, !i_valid)

endmodule

bind equalized_color_map ecm_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_valid(o_valid), .i_out_word(o_word)
);

FILE: test/equalized_color_map_test.sv
`timescale 1ns / 1ps

module equalized_color_map_test;

    localparam int MAX_SAMPLES  = 1024;
    localparam int BIN_COUNT    = 100;
    localparam int TABLE_DEPTH  = BIN_COUNT + 1;
    localparam int ITEM_TARGET  = 560;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int unsigned FULL_SCALE = ecm_pkg::FULL_SCALE;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ecm_pkg::t_in_word  i_word;
    logic               o_valid;
    ecm_pkg::t_out_word o_word;

    equalized_color_map #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .BIN_COUNT  (BIN_COUNT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_word (i_word),
        .o_valid(o_valid),
        .o_word (o_word)
    );

    // Words waiting to be sent, and results the colour map owes us.
    ecm_pkg::t_in_word  pending_words[$];
    ecm_pkg::t_out_word owed_results[$];

    int     mismatch_count = 0;
    int     words_taken    = 0;
    longint cycle_count    = 0;

    // Shadow copy of the block's state.
    int          shadow_samples[MAX_SAMPLES];
    int unsigned shadow_count;
    bit          shadow_dropped;
    int unsigned shadow_bp[TABLE_DEPTH];
    int unsigned shadow_map[TABLE_DEPTH];
    int unsigned shadow_bp_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    function automatic void queue_word(input ecm_pkg::t_in_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void owe_result(input ecm_pkg::t_out_word r);
        owed_results = {owed_results, r};
    endfunction

    function automatic longint grid(input longint k);
        return (k * FULL_SCALE) / BIN_COUNT;
    endfunction

    // Sort the held samples, normalise them and walk the grid to lay down
    // breakpoints with their cumulative-fraction map values.
    function automatic void build_equalized_table();
        int unsigned n;
        int unsigned cnt;
        longint      k;
        longint      run;
        longint      cum;
        longint      lo;
        longint      span;
        longint      d;
        longint      v;
        int          held;
        int          j;
        n = shadow_count;
        shadow_bp_count = 0;
        if (n < 2)
            return;
        for (int i = 1; i < n; i++) begin
            held = shadow_samples[i];
            j = i;
            while (j > 0 && shadow_samples[j-1] > held) begin
                shadow_samples[j] = shadow_samples[j-1];
                j--;
            end
            shadow_samples[j] = held;
        end
        lo = shadow_samples[0];
        if (longint'(shadow_samples[n-1]) == lo)
            return;
        span = longint'(shadow_samples[n-1]) - lo;
        shadow_bp[0]  = 0;
        shadow_map[0] = 0;
        cnt = 1;
        k = 1;
        run = 1;
        cum = 0;
        for (int i = 1; i < n && cnt < TABLE_DEPTH; i++) begin
            d = longint'(shadow_samples[i]) - lo;
            v = (d <<< 16) / span;
            if (v >= grid(k)) begin
                if (v == FULL_SCALE) begin
                    shadow_bp[cnt]  = FULL_SCALE;
                    shadow_map[cnt] = FULL_SCALE;
                    cnt++;
                    break;
                end
                while (v >= grid(k + 1))
                    k++;
                cum += run;
                shadow_bp[cnt]  = 32'(grid(k));
                shadow_map[cnt] = 32'((cum * FULL_SCALE) / n);
                cnt++;
                k++;
                run = 1;
            end else begin
                run++;
            end
        end
        shadow_bp_count = cnt;
    endfunction

    function automatic int unsigned colour_for(input int unsigned q);
        longint a;
        longint b;
        longint ma;
        longint mb;
        longint rise;
        longint step;
        if (q == FULL_SCALE)
            return FULL_SCALE;
        for (int i = 0; i + 1 < shadow_bp_count; i++) begin
            a = shadow_bp[i];
            b = shadow_bp[i+1];
            if (q >= a && q < b) begin
                ma = shadow_map[i];
                mb = shadow_map[i+1];
                rise = (mb >= ma) ? mb - ma : 0;
                step = ((q - a) * rise) / (b - a);
                return 32'((ma + step) & 'h1FFFF);
            end
        end
        return FULL_SCALE;
    endfunction

    // Work out what an accepted word owes, if anything, and queue it.
    function automatic void predict_word(input ecm_pkg::t_in_word w);
        ecm_pkg::t_out_word r;
        if (w.req_type == ecm_pkg::REQ_QUERY) begin
            r.color_value = 17'(colour_for(32'(w.query_value)));
            r.status      = ecm_pkg::STAT_ANSWER;
            owe_result(r);
            return;
        end
        if (shadow_count < MAX_SAMPLES) begin
            shadow_samples[shadow_count] = int'(w.stress_sample);
            shadow_count++;
        end else begin
            shadow_dropped = 1'b1;
        end
        if (!w.last_sample)
            return;
        build_equalized_table();
        r.color_value = '0;
        r.status      = shadow_dropped ? ecm_pkg::STAT_DROPPED : ecm_pkg::STAT_BUILT;
        owe_result(r);
        shadow_count   = 0;
        shadow_dropped = 1'b0;
    endfunction

    function automatic void add_load(input int s, input bit last);
        ecm_pkg::t_in_word w;
        w.req_type      = ecm_pkg::REQ_LOAD;
        w.stress_sample = s;
        w.last_sample   = last;
        w.query_value   = 17'($urandom_range(17'h1FFFF));  // ignored on loads
        queue_word(w);
    endfunction

    function automatic void add_query(input int unsigned q);
        ecm_pkg::t_in_word w;
        w.req_type      = ecm_pkg::REQ_QUERY;
        w.stress_sample = $urandom;                 // ignored on queries
        w.last_sample   = 1'($urandom_range(1));
        w.query_value   = 17'(q);
        queue_word(w);
    endfunction

    function automatic int unsigned random_query();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return FULL_SCALE;
        if (pick < 14)
            return $urandom_range(17'h1FFFF, FULL_SCALE + 1);
        if (pick < 18)
            return 0;
        return $urandom_range(FULL_SCALE - 1);
    endfunction

    // One well-formed data set with random content of a chosen flavour.
    function automatic void add_data_set(input int n, input int flavour);
        int base;
        int s;
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            case (flavour)
                0: s = $urandom;
                1: s = base + $urandom_range(7);
                2: s = base + $urandom_range(2000);
                default: s = (base >>> 4) + i * $urandom_range(3, 1);
            endcase
            add_load(s, i == n - 1);
        end
    endfunction

    function automatic void fill_stimulus();
        int n;
        // No table yet: everything answers full scale.
        add_query(0);
        add_query(FULL_SCALE);
        add_query(17'h1FFFF);
        // Single sample, then a constant set: still no table.
        add_load(42, 1'b1);
        add_query(100);
        add_load(-5, 1'b0);
        add_load(-5, 1'b0);
        add_load(-5, 1'b1);
        add_query(30000);
        // Extremes of the sample range.
        add_load(32'sh8000_0000, 1'b0);
        add_load(32'sh7FFF_FFFF, 1'b0);
        add_load(0, 1'b0);
        add_load(1, 1'b0);
        add_load(-1, 1'b1);
        add_query(0);
        add_query(32768);
        add_query(65535);
        add_query(FULL_SCALE);
        add_query(70000);
        add_query(17'h1FFFF);
        // Random part: mostly data sets followed by queries, some stray queries.
        while (pending_words.size() < ITEM_TARGET) begin
            if ($urandom_range(99) < 70) begin
                n = ($urandom_range(99) < 4) ? $urandom_range(200, 80) : $urandom_range(24, 2);
                add_data_set(n, $urandom_range(3));
                repeat ($urandom_range(6, 1)) add_query(random_query());
            end else begin
                add_query(random_query());
            end
        end
        // Overfill the store with ascending samples (cheap to sort); the
        // dropped last sample must still build.
        for (int i = 0; i <= MAX_SAMPLES; i++)
            add_load(i * 977 - 500000, i == MAX_SAMPLES);
        repeat (8) add_query(random_query());
        add_query(FULL_SCALE);
    endfunction

    // Driver: hold a word until taken, then advance or idle.
    always @(posedge i_clk) begin
        bit idle_now;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_word <= '0;
        end else begin
            if (start && !busy) begin
                predict_word(i_word);
                words_taken++;
            end
            if (!start || !busy) begin
                idle_now = (words_taken < 500 || words_taken > 900) && $urandom_range(99) < 24;
                if (pending_words.size() != 0 && !idle_now) begin
                    i_word <= pending_words.pop_front();
                    start  <= 1'b1;
                end else begin
                    start  <= 1'b0;
                end
            end
        end
    end

    // Monitor: take each strobed word and check against the oldest owed one.
    always @(posedge i_clk) begin
        ecm_pkg::t_out_word want;
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                report("unexpected result, status", 0, 32'(o_word.status));
            end else begin
                want = owed_results.pop_front();
                if (o_word.status !== want.status)
                    report("status", 32'(want.status), 32'(o_word.status));
                if (o_word.color_value !== want.color_value)
                    report("color_value", 32'(want.color_value), 32'(o_word.color_value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        start           = 1'b0;
        i_word          = '0;
        i_rst_n         = 1'b0;
        shadow_count    = 0;
        shadow_dropped  = 1'b0;
        shadow_bp_count = 0;
        fill_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Drain: everything sent, then everything owed, then let it settle.
        wait (pending_words.size() == 0 && !start);
        wait (owed_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: equalized_color_map.f
+incdir+hdl
hdl/ecm_pkg.sv
hdl/ecm_ram.sv
hdl/ecm_div.sv
hdl/equalized_color_map.sv
hdl/ecm_checker.sv
test/equalized_color_map_test.sv
